@@ rtl/ggcu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggcu_pkg
// Shared types and constants for the grain growth cell update block.
// ----------------------------------------------------------------------------
package ggcu_pkg;

   localparam int GRID_HEIGHT = 64;
   localparam int GRID_WIDTH  = 64;
   localparam int ROW_W  = 6;
   localparam int COL_W  = 6;
   localparam int ADDR_W = $clog2(GRID_HEIGHT * GRID_WIDTH);
   localparam int ID_W   = 12;
   localparam int EN_W   = 8;
   localparam int CNT_W  = 4;
   localparam int BIAS_W = 6;
   localparam int NB_N   = 8;
   localparam int NB_W   = 3;

   localparam logic [1:0] CMD_LOAD   = 2'd0;
   localparam logic [1:0] CMD_UPDATE = 2'd1;
   localparam logic [1:0] CMD_READ   = 2'd2;
   localparam logic [1:0] CMD_SPARE  = 2'd3;   // unused code, behaves as read

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,     // read addressed cell
      ST_GATHER,   // fetch neighbours, one per cycle
      ST_TALLY,    // count each gathered id, one per cycle
      ST_WRITE,    // write back / respond
      ST_DONE
   } state_type;

   typedef struct packed {
      logic       capture;   // latch request
      logic       rd_cell;   // issue read of addressed cell
      logic       rd_nb;     // issue read of neighbour nb_idx
      logic       grab_nb;   // store returned neighbour
      logic       tally;     // count candidate tally_idx
      logic       commit;    // write back and build result
      logic [NB_W-1:0] nb_idx;
      logic [NB_W-1:0] grab_idx;
      logic [NB_W-1:0] tally_idx;
   } ctrl_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       out_of_grid;
   } status_type;

endpackage

@@ rtl/grain_growth_cell_update.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grain_growth_cell_update
// Cellular-automaton recrystallization step on a 64x64 Moore grid.
// ----------------------------------------------------------------------------
// Usage: raise start with req_* fields while busy is low; that edge is the
// transfer. Commands: load writes a cell, read returns it, update tallies
// negative neighbour ids and may recrystallize the cell.
// Each command yields one result on rsp_* marked by rsp_strobe for exactly
// one cycle; the receiver cannot stall, so the result must be taken then.
// Steps: load/read read the cell and go to write-back; update reads the cell,
// makes eight neighbour reads through the single grid read port, grabs the
// last neighbour data from the read register, takes eight tally steps and
// writes back. busy stays high through the strobe cycle and drops in the
// cycle after it.
// csr_valid/csr_ready write bias_h; csr_ready is always high.
// Reset clears the sequencer and bias_h; grid contents are undefined until
// loaded. No clearing pass is run.
// ----------------------------------------------------------------------------
module grain_growth_cell_update (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_cmd,
   input  logic [ggcu_pkg::ROW_W-1:0]          req_row,
   input  logic [ggcu_pkg::COL_W-1:0]          req_col,
   input  logic signed [ggcu_pkg::ID_W-1:0]    req_load_id,
   input  logic [ggcu_pkg::EN_W-1:0]           req_load_energy,
   output logic                                rsp_strobe,
   output logic signed [ggcu_pkg::ID_W-1:0]    rsp_cell_id,
   output logic [ggcu_pkg::EN_W-1:0]           rsp_cell_energy,
   output logic                                rsp_changed,
   output logic signed [ggcu_pkg::ID_W-1:0]    rsp_winner_id,
   output logic [ggcu_pkg::CNT_W-1:0]          rsp_winner_count,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic signed [ggcu_pkg::BIAS_W-1:0]  csr_bias_h
);

   ggcu_pkg::ctrl_type   ctrl;
   ggcu_pkg::status_type status;
   logic signed [ggcu_pkg::BIAS_W-1:0] bias_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset)          bias_ff <= '0;
      else if (csr_valid) bias_ff <= csr_bias_h;
   end

   ggcu_ctrl u_ctrl (
      .clock (clock), .reset (reset), .start (start),
      .status(status), .busy (busy), .ctrl (ctrl)
   );

   ggcu_datapath u_dp (
      .clock (clock), .reset (reset), .ctrl (ctrl), .status (status),
      .req_cmd (req_cmd), .req_row (req_row), .req_col (req_col),
      .req_load_id (req_load_id), .req_load_energy (req_load_energy),
      .bias (bias_ff),
      .rsp_strobe (rsp_strobe), .rsp_cell_id (rsp_cell_id),
      .rsp_cell_energy (rsp_cell_energy), .rsp_changed (rsp_changed),
      .rsp_winner_id (rsp_winner_id), .rsp_winner_count (rsp_winner_count)
   );

endmodule

@@ rtl/ggcu_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggcu_ctrl
// Command sequencer: read, then gather and tally on update, then commit.
// ----------------------------------------------------------------------------
module ggcu_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  ggcu_pkg::status_type  status,
   output logic                  busy,
   output ggcu_pkg::ctrl_type    ctrl
);

   ggcu_pkg::state_type state_ff, state_in;
   logic [ggcu_pkg::NB_W:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ggcu_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      ctrl     = '0;
      busy     = 1'b1;
      ctrl.nb_idx    = cnt_ff[ggcu_pkg::NB_W-1:0];
      ctrl.grab_idx  = cnt_ff[ggcu_pkg::NB_W-1:0] - 3'd1;
      ctrl.tally_idx = cnt_ff[ggcu_pkg::NB_W-1:0];
      case (state_ff)
         ggcu_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               ctrl.capture = 1'b1;
               state_in = ggcu_pkg::ST_READ;
            end
         end
         ggcu_pkg::ST_READ: begin
            ctrl.rd_cell = 1'b1;
            cnt_in = '0;
            if (status.out_of_grid || status.cmd != ggcu_pkg::CMD_UPDATE)
               state_in = ggcu_pkg::ST_WRITE;
            else
               state_in = ggcu_pkg::ST_GATHER;
         end
         ggcu_pkg::ST_GATHER: begin
            // read issued at cnt, data lands next cycle
            ctrl.rd_nb   = (cnt_ff < 4'd8);
            ctrl.grab_nb = (cnt_ff != 4'd0);
            if (cnt_ff == 4'd8) begin
               cnt_in   = '0;
               state_in = ggcu_pkg::ST_TALLY;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         ggcu_pkg::ST_TALLY: begin
            ctrl.tally = 1'b1;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd7)
               state_in = ggcu_pkg::ST_WRITE;
         end
         ggcu_pkg::ST_WRITE: begin
            ctrl.commit = 1'b1;
            state_in = ggcu_pkg::ST_DONE;
         end
         ggcu_pkg::ST_DONE: begin
            state_in = ggcu_pkg::ST_IDLE;
         end
         default: state_in = ggcu_pkg::ST_IDLE;
      endcase
   end

endmodule

@@ rtl/ggcu_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggcu_datapath
// Grid memories, neighbour buffer, tally unit and result register.
// ----------------------------------------------------------------------------
module ggcu_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  ggcu_pkg::ctrl_type                  ctrl,
   output ggcu_pkg::status_type                status,
   input  logic [1:0]                          req_cmd,
   input  logic [ggcu_pkg::ROW_W-1:0]          req_row,
   input  logic [ggcu_pkg::COL_W-1:0]          req_col,
   input  logic signed [ggcu_pkg::ID_W-1:0]    req_load_id,
   input  logic [ggcu_pkg::EN_W-1:0]           req_load_energy,
   input  logic signed [ggcu_pkg::BIAS_W-1:0]  bias,
   output logic                                rsp_strobe,
   output logic signed [ggcu_pkg::ID_W-1:0]    rsp_cell_id,
   output logic [ggcu_pkg::EN_W-1:0]           rsp_cell_energy,
   output logic                                rsp_changed,
   output logic signed [ggcu_pkg::ID_W-1:0]    rsp_winner_id,
   output logic [ggcu_pkg::CNT_W-1:0]          rsp_winner_count
);

   localparam int AW = ggcu_pkg::ADDR_W;
   localparam int IW = ggcu_pkg::ID_W;
   localparam int EW = ggcu_pkg::EN_W;
   localparam int CW = ggcu_pkg::CNT_W;

   logic [IW-1:0] grain_mem [ggcu_pkg::GRID_HEIGHT*ggcu_pkg::GRID_WIDTH];
   logic [EW-1:0] energy_mem [ggcu_pkg::GRID_HEIGHT*ggcu_pkg::GRID_WIDTH];

   logic [1:0]    cmd_ff;
   logic [ggcu_pkg::ROW_W-1:0] row_ff;
   logic [ggcu_pkg::COL_W-1:0] col_ff;
   logic [IW-1:0] lid_ff;
   logic [EW-1:0] len_ff;
   logic          oog_ff;

   logic [IW-1:0] rd_id_ff;
   logic [EW-1:0] rd_en_ff;
   logic [IW-1:0] cell_id_ff;
   logic [EW-1:0] cell_en_ff;
   logic          cell_grab_ff;

   logic [IW-1:0] nb_id_ff [ggcu_pkg::NB_N];
   logic          nb_ok_ff [ggcu_pkg::NB_N];
   logic          nb_ok_pipe_ff;

   logic [IW-1:0] win_id_ff;
   logic [CW-1:0] win_cnt_ff;

   // neighbour address for nb_idx (scan order, center skipped)
   logic signed [ggcu_pkg::ROW_W+1:0] nr, nc;
   logic [1:0] dr_code, dc_code;
   logic       nb_ok;
   logic [AW-1:0] rd_addr;

   always_comb begin
      dr_code = (ctrl.nb_idx < 3'd3) ? 2'd0 : ((ctrl.nb_idx < 3'd5) ? 2'd1 : 2'd2);
      dc_code = 2'd0;
      case (ctrl.nb_idx)
         3'd0, 3'd3, 3'd5: dc_code = 2'd0;
         3'd1, 3'd6:       dc_code = 2'd1;
         default:          dc_code = 2'd2;
      endcase
      nr = $signed({2'b00, row_ff}) + $signed({6'd0, dr_code}) - 8'sd1;
      nc = $signed({2'b00, col_ff}) + $signed({6'd0, dc_code}) - 8'sd1;
      nb_ok = (nr >= 0) && (nc >= 0) && (nr < ggcu_pkg::GRID_HEIGHT)
            && (nc < ggcu_pkg::GRID_WIDTH);
      if (ctrl.rd_nb)
         rd_addr = AW'(nr[ggcu_pkg::ROW_W-1:0] * ggcu_pkg::GRID_WIDTH
                       + nc[ggcu_pkg::COL_W-1:0]);
      else
         rd_addr = AW'(row_ff * ggcu_pkg::GRID_WIDTH + col_ff);
   end

   logic [AW-1:0] cell_addr;
   assign cell_addr = AW'(row_ff * ggcu_pkg::GRID_WIDTH + col_ff);

   // tally: count occurrences of candidate tally_idx across buffer
   logic [CW-1:0] cand_cnt;
   logic [IW-1:0] cand_id;
   always_comb begin
      cand_id  = nb_id_ff[ctrl.tally_idx];
      cand_cnt = '0;
      for (int m = 0; m < ggcu_pkg::NB_N; m++)
         if (nb_ok_ff[m] && nb_id_ff[m] == cand_id)
            cand_cnt = cand_cnt + CW'(1);
      if (!nb_ok_ff[ctrl.tally_idx] || !cand_id[IW-1])
         cand_cnt = '0;
   end

   // one extra bit so count 8 plus the largest bias cannot wrap
   logic do_change;
   logic signed [CW+2:0] sum;
   always_comb begin
      sum = $signed({3'b000, win_cnt_ff}) + $signed({bias[ggcu_pkg::BIAS_W-1], bias});
      do_change = (cmd_ff == ggcu_pkg::CMD_UPDATE) && (win_cnt_ff != '0)
                && (cell_en_ff != '0) && (sum > 0);
   end

   assign status.cmd = cmd_ff;
   assign status.out_of_grid = oog_ff;

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         cmd_ff <= req_cmd;
         row_ff <= req_row;
         col_ff <= req_col;
         lid_ff <= req_load_id;
         len_ff <= req_load_energy;
         oog_ff <= (req_row >= ggcu_pkg::GRID_HEIGHT) || (req_col >= ggcu_pkg::GRID_WIDTH);
      end
      rd_id_ff <= grain_mem[rd_addr];
      rd_en_ff <= energy_mem[rd_addr];
      nb_ok_pipe_ff <= nb_ok;
      cell_grab_ff <= ctrl.rd_cell;
      if (cell_grab_ff) begin
         cell_id_ff <= rd_id_ff;
         cell_en_ff <= rd_en_ff;
      end
      if (ctrl.grab_nb) begin
         nb_id_ff[ctrl.grab_idx] <= rd_id_ff;
         nb_ok_ff[ctrl.grab_idx] <= nb_ok_pipe_ff;
      end
      if (ctrl.rd_cell) begin
         win_id_ff  <= '0;
         win_cnt_ff <= '0;
      end else if (ctrl.tally && cand_cnt > win_cnt_ff) begin
         win_id_ff  <= cand_id;
         win_cnt_ff <= cand_cnt;
      end
      if (ctrl.commit && !oog_ff) begin
         if (cmd_ff == ggcu_pkg::CMD_LOAD) begin
            grain_mem[cell_addr]  <= lid_ff;
            energy_mem[cell_addr] <= len_ff;
         end else if (do_change) begin
            grain_mem[cell_addr]  <= win_id_ff;
            energy_mem[cell_addr] <= '0;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) rsp_strobe <= 1'b0;
      else       rsp_strobe <= ctrl.commit;
      if (ctrl.commit) begin
         rsp_cell_id      <= '0;
         rsp_cell_energy  <= '0;
         rsp_changed      <= 1'b0;
         rsp_winner_id    <= '0;
         rsp_winner_count <= '0;
         if (!oog_ff) begin
            if (cmd_ff == ggcu_pkg::CMD_LOAD) begin
               rsp_cell_id     <= lid_ff;
               rsp_cell_energy <= len_ff;
            end else if (cmd_ff == ggcu_pkg::CMD_UPDATE) begin
               rsp_winner_id    <= win_id_ff;
               rsp_winner_count <= win_cnt_ff;
               rsp_changed      <= do_change;
               rsp_cell_id      <= do_change ? win_id_ff : cell_id_ff;
               rsp_cell_energy  <= do_change ? '0 : cell_en_ff;
            end else begin
               // read goes straight from read to commit; cell data is in rd_*_ff
               rsp_cell_id     <= rd_id_ff;
               rsp_cell_energy <= rd_en_ff;
            end
         end
      end
   end

endmodule

@@ rtl/ggcu_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggcu_port_checks
// Port-level checks for grain_growth_cell_update.
// ----------------------------------------------------------------------------
module ggcu_port_checks (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic        rsp_changed,
   input logic [7:0]  rsp_cell_energy,
   input logic [3:0]  rsp_winner_count
);

   // a transfer makes the block busy
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("busy not raised");

   // strobe only while the command is in flight
   a_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy) else $error("strobe while idle");

   // a change empties the cell energy and needs a nonzero winner count
   a_chg: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_changed) |-> (rsp_cell_energy == 8'd0 && rsp_winner_count != 4'd0))
      else $error("change without zero energy");

   // strobes are single pulses
   a_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("strobe longer than a cycle");

endmodule

bind grain_growth_cell_update ggcu_port_checks u_ggcu_port_checks (
   .clock (clock), .reset (reset), .start (start), .busy (busy),
   .rsp_strobe (rsp_strobe), .rsp_changed (rsp_changed),
   .rsp_cell_energy (rsp_cell_energy), .rsp_winner_count (rsp_winner_count)
);
